// ===== rtl/envmap_direction_to_texel_macros.svh =====
// ============================================================================
// envmap_direction_to_texel_macros.svh
// assertion macros shared by the environment map checker
// ============================================================================
`ifndef ENVMAP_DIRECTION_TO_TEXEL_MACROS_SVH
`define ENVMAP_DIRECTION_TO_TEXEL_MACROS_SVH

// same-cycle implication, disabled during reset
`define ENVMAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ENVMAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/envmap_pkg.sv =====
// ============================================================================
// envmap_pkg
// types and fixed-point constants for the environment map texel lookup
// ============================================================================
package envmap_pkg;

    localparam int FRAC_BITS    = 15;
    localparam int MAX_MAP_SIZE = 4096;
    localparam int TAYLOR_TERMS = 17;

    // q15 constants
    localparam logic [15:0] LOG2E_F = 16'd47274;
    localparam logic [14:0] LN2_F   = 15'd22713;
    localparam logic [14:0] C095_F  = 15'd31130;
    localparam logic [14:0] HALF_F  = 15'd16384;
    localparam logic [15:0] ONE_F   = 16'd32768;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAP_WIDTH      = 2'd0;
    localparam t_cfg_idx CFG_MAP_HEIGHT     = 2'd1;
    localparam t_cfg_idx CFG_POLE_THRESHOLD = 2'd2;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_dir_in;

    typedef struct packed {
        logic [11:0] texel_column;
        logic [11:0] texel_row;
        logic        is_black;
    } t_texel_out;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        w;
        logic               black;
        logic               zero;
    } t_side;

    // ceil(2^20 / k), exact floor division of 15-bit values by k
    function automatic logic [20:0] recip_q20(input logic [4:0] k);
        logic [20:0] m;
        case (k)
            5'd1:    m = 21'd1048576;
            5'd2:    m = 21'd524288;
            5'd3:    m = 21'd349526;
            5'd4:    m = 21'd262144;
            5'd5:    m = 21'd209716;
            5'd6:    m = 21'd174763;
            5'd7:    m = 21'd149797;
            5'd8:    m = 21'd131072;
            5'd9:    m = 21'd116509;
            5'd10:   m = 21'd104858;
            5'd11:   m = 21'd95326;
            5'd12:   m = 21'd87382;
            5'd13:   m = 21'd80660;
            5'd14:   m = 21'd74899;
            5'd15:   m = 21'd69906;
            5'd16:   m = 21'd65536;
            default: m = 21'd1048576;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/envmap_direction_to_texel.sv =====
// ============================================================================
// envmap_direction_to_texel
// unit direction to stereographic environment map texel, fully pipelined
// ============================================================================
// Accepts one direction per clock while the output is not stalled and
// returns its texel after the pipeline: the bit-per-stage square root (32
// stages), the radius divider (19), the exponential series (two stages for
// each of the 16 terms after the leading one), the sigmoid divider (16) and
// the coordinate dividers (14). A stall on the output freezes the whole
// pipeline. Directions within pole_threshold of the +z pole come out flagged
// black at texel (0, 0).
module envmap_direction_to_texel (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  envmap_pkg::t_dir_in      i_dir,
    output logic                     o_stall,
    output logic                     o_valid,
    output envmap_pkg::t_texel_out   o_texel,
    input  logic                     i_stall,
    input  logic                     i_cfg_we,
    input  envmap_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [14:0]              i_cfg_wdata
);

    localparam int ST_H2     = 1;
    localparam int SQ_STEPS  = 32;
    localparam int ST_HQ     = ST_H2 + SQ_STEPS;
    localparam int ST_RF0    = ST_HQ + 1;
    localparam int RF_STEPS  = 19;
    localparam int ST_RF     = ST_RF0 + RF_STEPS;
    localparam int ST_T      = ST_RF + 1;
    localparam int ST_P      = ST_T + 1;
    localparam int ST_A      = ST_P + 1;
    localparam int TAY_STEPS = envmap_pkg::TAYLOR_TERMS - 1;
    localparam int ST_SUM    = ST_A + 2 * TAY_STEPS;
    localparam int ST_E      = ST_SUM + 1;
    localparam int S_STEPS   = 16;
    localparam int ST_S      = ST_E + S_STEPS;
    localparam int ST_D      = ST_S + 1;
    localparam int ST_G      = ST_D + 1;
    localparam int ST_N      = ST_G + 1;
    localparam int C_STEPS   = 14;
    localparam int ST_C      = ST_N + C_STEPS;
    localparam int ST_UV     = ST_C + 1;
    localparam int ST_OUT    = ST_UV + 1;
    localparam int NS        = ST_OUT + 1;

    localparam logic [12:0] MAP_MAX = 13'(envmap_pkg::MAX_MAP_SIZE);

    logic [12:0] r_map_width;
    logic [12:0] r_map_height;
    logic [14:0] r_pole_thr;

    logic [NS-1:0] r_vld;
    logic          c_en;

    envmap_pkg::t_side r_sd [0:ST_UV];

    logic [30:0] r_x2;
    logic [30:0] r_y2;

    logic [31:0] r_sq_src  [ST_H2:ST_H2+SQ_STEPS/2-1];
    logic [33:0] r_sq_rem  [ST_H2:ST_HQ-1];
    logic [31:0] r_sq_root [ST_H2:ST_HQ];

    logic [31:0] r_hq     [ST_RF0:ST_C-1];
    logic [31:0] r_rf_rem [ST_RF0:ST_RF-1];
    logic [17:0] r_rf_dv  [ST_RF0:ST_RF-1];
    logic [18:0] r_rf_q   [ST_RF0:ST_RF];
    logic        r_rf_sat [ST_RF0:ST_RF];

    logic [20:0] r_t;
    logic [20:0] r_p;

    logic [14:0] r_ty_a   [ST_A:ST_SUM-2];
    logic [5:0]  r_ty_n   [ST_A:ST_SUM];
    logic [15:0] r_ty_val [ST_A:ST_SUM-1];
    logic [16:0] r_ty_sum [ST_A:ST_SUM];

    logic [30:0] r_s_rem [ST_E:ST_S-1];
    logic [16:0] r_s_dv  [ST_E:ST_S-1];
    logic [15:0] r_s_q   [ST_E:ST_S];

    logic [14:0] r_d;
    logic [13:0] r_g;

    logic [45:0] r_cx_rem [ST_N:ST_C-1];
    logic [45:0] r_cy_rem [ST_N:ST_C-1];
    logic [13:0] r_cx_q   [ST_N:ST_C];
    logic [13:0] r_cy_q   [ST_N:ST_C];

    logic [14:0] r_u;
    logic [14:0] r_v;

    envmap_pkg::t_texel_out r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 13'd1024;
            r_map_height <= 13'd1024;
            r_pole_thr   <= 15'd33;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                envmap_pkg::CFG_MAP_WIDTH:      r_map_width  <= i_cfg_wdata[12:0];
                envmap_pkg::CFG_MAP_HEIGHT:     r_map_height <= i_cfg_wdata[12:0];
                envmap_pkg::CFG_POLE_THRESHOLD: r_pole_thr   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign c_en    = !r_vld[NS-1] || !i_stall;
    assign o_stall = !c_en;
    assign o_valid = r_vld[NS-1];
    assign o_texel = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (c_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // input stage
    logic signed [31:0] c_x2;
    logic signed [31:0] c_y2;
    logic [16:0]        c_w;

    assign c_x2 = $signed(i_dir.dir_x) * $signed(i_dir.dir_x);
    assign c_y2 = $signed(i_dir.dir_y) * $signed(i_dir.dir_y);
    assign c_w  = 17'h08000 - {i_dir.dir_z[15], i_dir.dir_z};

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sd[0].x     <= i_dir.dir_x;
            r_sd[0].y     <= i_dir.dir_y;
            r_sd[0].w     <= c_w;
            r_sd[0].black <= c_w < {2'b00, r_pole_thr};
            r_sd[0].zero  <= (i_dir.dir_x == 16'sd0) && (i_dir.dir_y == 16'sd0);
            r_x2          <= c_x2[30:0];
            r_y2          <= c_y2[30:0];
        end
    end

    for (genvar k = 1; k <= ST_UV; k++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_sd[k] <= r_sd[k-1];
            end
        end
    end

    // squared radius
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_sq_src[ST_H2]  <= {1'b0, r_x2} + {1'b0, r_y2};
            r_sq_rem[ST_H2]  <= '0;
            r_sq_root[ST_H2] <= '0;
        end
    end

    for (genvar k = ST_H2 + 1; k < ST_H2 + SQ_STEPS / 2; k++) begin : g_sq_src
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_sq_src[k] <= r_sq_src[k-1];
            end
        end
    end

    // square root of h2 * 2^32, one result bit per stage
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
        localparam int K = ST_H2 + 1 + j;
        logic [1:0]  c_pair;
        logic [35:0] c_rem;
        logic [35:0] c_test;
        logic [35:0] c_dif;
        logic        c_ge;

        if (j < SQ_STEPS / 2) begin : g_pair
            assign c_pair = r_sq_src[K-1][31-2*j -: 2];
        end else begin : g_low
            assign c_pair = 2'b00;
        end

        assign c_rem  = {r_sq_rem[K-1], c_pair};
        assign c_test = {2'b00, r_sq_root[K-1], 2'b01};
        assign c_ge   = c_rem >= c_test;
        assign c_dif  = c_rem - c_test;

        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_sq_root[K] <= {r_sq_root[K-1][30:0], c_ge};
            end
        end

        if (j < SQ_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_sq_rem[K] <= c_ge ? c_dif[33:0] : c_rem[33:0];
                end
            end
        end
    end

    // radius divider hq / 2w, saturated
    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_hq[ST_RF0]     <= r_sq_root[ST_HQ];
            r_rf_rem[ST_RF0] <= r_sq_root[ST_HQ];
            r_rf_dv[ST_RF0]  <= {r_sd[ST_HQ].w, 1'b0};
            r_rf_sat[ST_RF0] <= {5'b0, r_sq_root[ST_HQ][31:19]} >= {r_sd[ST_HQ].w, 1'b0};
            r_rf_q[ST_RF0]   <= '0;
        end
    end

    for (genvar k = ST_RF0 + 1; k < ST_C; k++) begin : g_hq
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_hq[k] <= r_hq[k-1];
            end
        end
    end

    for (genvar i = 0; i < RF_STEPS; i++) begin : g_rf
        localparam int K = ST_RF0 + 1 + i;
        localparam int B = RF_STEPS - 1 - i;
        logic [35:0] c_sh;
        logic        c_ge;

        assign c_sh = {18'b0, r_rf_dv[K-1]} << B;
        assign c_ge = {4'b0, r_rf_rem[K-1]} >= c_sh;

        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_rf_q[K]   <= c_ge ? (r_rf_q[K-1] | (19'd1 << B)) : r_rf_q[K-1];
                r_rf_sat[K] <= r_rf_sat[K-1];
            end
        end

        if (K < ST_RF) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_rf_rem[K] <= c_ge ? (r_rf_rem[K-1] - c_sh[31:0]) : r_rf_rem[K-1];
                    r_rf_dv[K]  <= r_rf_dv[K-1];
                end
            end
        end
    end

    // exponent argument
    logic [36:0] c_pm;
    logic [30:0] c_am;

    assign c_pm = 37'(r_t) * 37'(envmap_pkg::LOG2E_F);
    assign c_am = 31'(envmap_pkg::ONE_F - {1'b0, r_p[14:0]}) * 31'(envmap_pkg::LN2_F);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_t <= (r_rf_sat[ST_RF] || r_rf_q[ST_RF][18]) ? 21'h100000
                                                          : {1'b0, r_rf_q[ST_RF][17:0], 2'b00};
            r_p <= c_pm[35:15];
            r_ty_a[ST_A]   <= c_am[29:15];
            r_ty_n[ST_A]   <= r_p[20:15];
            r_ty_val[ST_A] <= envmap_pkg::ONE_F;
            r_ty_sum[ST_A] <= {1'b0, envmap_pkg::ONE_F};
        end
    end

    for (genvar k = ST_A + 1; k <= ST_SUM - 2; k++) begin : g_ty_a
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_ty_a[k] <= r_ty_a[k-1];
            end
        end
    end

    for (genvar k = ST_A + 1; k <= ST_SUM; k++) begin : g_ty_n
        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_ty_n[k] <= r_ty_n[k-1];
            end
        end
    end

    // taylor series, two stages per term
    for (genvar t = 1; t <= TAY_STEPS; t++) begin : g_ty
        localparam int KO = ST_A + 2 * t - 1;
        localparam int KE = ST_A + 2 * t;
        logic [30:0] c_vm;
        logic [35:0] c_dm;

        assign c_vm = 31'(r_ty_val[KO-1]) * 31'(r_ty_a[KO-1]);
        assign c_dm = 36'(r_ty_val[KO][14:0]) * 36'(envmap_pkg::recip_q20(5'(t)));

        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_ty_val[KO] <= c_vm[30:15];
                r_ty_sum[KO] <= r_ty_sum[KO-1];
                r_ty_sum[KE] <= r_ty_sum[KO] + {1'b0, c_dm[35:20]};
            end
        end

        if (t < TAY_STEPS) begin : g_val
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_ty_val[KE] <= c_dm[35:20];
                end
            end
        end
    end

    // exp(-t) and sigmoid divider 2^30 / (1 + e)
    logic [6:0]  c_esh;
    logic [16:0] c_e;

    assign c_esh = {1'b0, r_ty_n[ST_SUM]} + 7'd1;
    assign c_e   = r_ty_sum[ST_SUM] >> c_esh;

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_s_rem[ST_E] <= 31'h40000000;
            r_s_dv[ST_E]  <= {1'b0, envmap_pkg::ONE_F} + c_e;
            r_s_q[ST_E]   <= '0;
        end
    end

    for (genvar i = 0; i < S_STEPS; i++) begin : g_sd
        localparam int K = ST_E + 1 + i;
        localparam int B = S_STEPS - 1 - i;
        logic [31:0] c_sh;
        logic        c_ge;

        assign c_sh = {15'b0, r_s_dv[K-1]} << B;
        assign c_ge = {1'b0, r_s_rem[K-1]} >= c_sh;

        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_s_q[K] <= c_ge ? (r_s_q[K-1] | (16'd1 << B)) : r_s_q[K-1];
            end
        end

        if (K < ST_S) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_s_rem[K] <= c_ge ? (r_s_rem[K-1] - c_sh[30:0]) : r_s_rem[K-1];
                    r_s_dv[K]  <= r_s_dv[K-1];
                end
            end
        end
    end

    // gain and numerators
    logic [15:0] c_sdif;
    logic [29:0] c_gm;
    logic [15:0] c_mx;
    logic [15:0] c_my;
    logic [29:0] c_nx;
    logic [29:0] c_ny;

    assign c_sdif = r_s_q[ST_S] - {1'b0, envmap_pkg::HALF_F};
    assign c_gm   = 30'(r_d) * 30'(envmap_pkg::C095_F);
    assign c_mx   = r_sd[ST_G].x[15] ? 16'(-r_sd[ST_G].x) : r_sd[ST_G].x;
    assign c_my   = r_sd[ST_G].y[15] ? 16'(-r_sd[ST_G].y) : r_sd[ST_G].y;
    assign c_nx   = 30'(c_mx) * 30'(r_g);
    assign c_ny   = 30'(c_my) * 30'(r_g);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_d <= (r_s_q[ST_S] > {1'b0, envmap_pkg::HALF_F}) ? c_sdif[14:0] : '0;
            r_g <= c_gm[28:15];
            r_cx_rem[ST_N] <= {c_nx, 16'b0};
            r_cy_rem[ST_N] <= {c_ny, 16'b0};
            r_cx_q[ST_N]   <= '0;
            r_cy_q[ST_N]   <= '0;
        end
    end

    // coordinate dividers, x and y side by side
    for (genvar i = 0; i < C_STEPS; i++) begin : g_cd
        localparam int K = ST_N + 1 + i;
        localparam int B = C_STEPS - 1 - i;
        logic [45:0] c_sh;
        logic        c_gex;
        logic        c_gey;

        assign c_sh  = {14'b0, r_hq[K-1]} << B;
        assign c_gex = r_cx_rem[K-1] >= c_sh;
        assign c_gey = r_cy_rem[K-1] >= c_sh;

        always_ff @(posedge i_clk) begin
            if (c_en) begin
                r_cx_q[K] <= c_gex ? (r_cx_q[K-1] | (14'd1 << B)) : r_cx_q[K-1];
                r_cy_q[K] <= c_gey ? (r_cy_q[K-1] | (14'd1 << B)) : r_cy_q[K-1];
            end
        end

        if (K < ST_C) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (c_en) begin
                    r_cx_rem[K] <= c_gex ? (r_cx_rem[K-1] - c_sh) : r_cx_rem[K-1];
                    r_cy_rem[K] <= c_gey ? (r_cy_rem[K-1] - c_sh) : r_cy_rem[K-1];
                end
            end
        end
    end

    // map coordinates and texel indices
    logic [11:0] c_wm1;
    logic [11:0] c_hm1;
    logic [26:0] c_cm;
    logic [26:0] c_rm;

    assign c_wm1 = (r_map_width == 13'd0)  ? 12'd0 :
                   (r_map_width > MAP_MAX) ? 12'(MAP_MAX - 13'd1) :
                                             12'(r_map_width - 13'd1);
    assign c_hm1 = (r_map_height == 13'd0)  ? 12'd0 :
                   (r_map_height > MAP_MAX) ? 12'(MAP_MAX - 13'd1) :
                                              12'(r_map_height - 13'd1);
    assign c_cm  = 27'(r_u) * 27'(c_wm1);
    assign c_rm  = 27'(r_v) * 27'(c_hm1);

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            if (r_sd[ST_C].zero) begin
                r_u <= envmap_pkg::HALF_F;
                r_v <= envmap_pkg::HALF_F;
            end else begin
                r_u <= r_sd[ST_C].x[15] ? envmap_pkg::HALF_F - {1'b0, r_cx_q[ST_C]}
                                        : envmap_pkg::HALF_F + {1'b0, r_cx_q[ST_C]};
                r_v <= r_sd[ST_C].y[15] ? envmap_pkg::HALF_F - {1'b0, r_cy_q[ST_C]}
                                        : envmap_pkg::HALF_F + {1'b0, r_cy_q[ST_C]};
            end
            r_out.is_black     <= r_sd[ST_UV].black;
            r_out.texel_column <= r_sd[ST_UV].black ? 12'd0 : c_cm[26:15];
            r_out.texel_row    <= r_sd[ST_UV].black ? 12'd0 : c_rm[26:15];
        end
    end

endmodule

// ===== rtl/envmap_chk.sv =====
// ============================================================================
// envmap_chk
// port-level checks for the environment map texel lookup
// ============================================================================
`include "envmap_direction_to_texel_macros.svh"

module envmap_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input envmap_pkg::t_texel_out o_texel,
    input logic                   i_stall
);

    `ENVMAP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_texel), "stalled output transaction changed")

    `ENVMAP_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without a blocked output transaction")

    `ENVMAP_ASSERT_NOW(a_black_origin, i_clk, i_rst_n, o_valid && o_texel.is_black, (o_texel.texel_column == 12'd0) && (o_texel.texel_row == 12'd0), "black transaction with nonzero texel")

endmodule

bind envmap_direction_to_texel envmap_chk u_envmap_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_texel (o_texel),
    .i_stall (i_stall)
);
